// ----- src/conv3s_pkg.sv -----
// ----------------------------------------------------------------------------
// conv3s_pkg
// shared constants, types and helpers for the 3x3 convolution stream
// ----------------------------------------------------------------------------
package conv3s_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int KERNEL_SIZE = 3;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 8;
  localparam int CFG_W  = KERNEL_SIZE * COEF_W;
  localparam int SIZE_W = 10;
  localparam int IDX_W  = 3;

  // line store address and column counter
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  // row counter
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  // compare width for counters against the effective geometry
  localparam int CMPW_W = (SIZE_W > ADDR_W + 1) ? SIZE_W : ADDR_W + 1;
  localparam int CMPH_W = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;

  // signed coefficient times zero-extended pixel
  localparam int PROD_W = COEF_W + PIX_W + 1;
  // nine products plus headroom
  localparam int SUM_W  = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);

  localparam logic [PIX_W-1:0] PIXEL_MAX = PIX_W'(255);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_COEFF_ROW0  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COEFF_ROW1  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_COEFF_ROW2  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(4);

  // data carried from cell to cell; taps row 0 is the row the next cell uses
  typedef struct packed {
    logic signed [SUM_W-1:0]                            sum;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] taps;
    logic                                               row_end;
    logic                                               frame_end;
  } cell_data_t;

  function automatic logic signed [SUM_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
    sext_prod = {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

// ----- src/conv3s_ram.sv -----
// ----------------------------------------------------------------------------
// conv3s_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module conv3s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/conv3s_cell.sv -----
// ----------------------------------------------------------------------------
// conv3s_cell
// one kernel row: three taps times three coefficients added to the running sum
// ----------------------------------------------------------------------------
module conv3s_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [conv3s_pkg::CFG_W-1:0]      coeff,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  conv3s_pkg::cell_data_t            in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output conv3s_pkg::cell_data_t            out_data
);

  logic                                      valid;
  conv3s_pkg::cell_data_t                    data;
  conv3s_pkg::cell_data_t                    data_next;
  logic signed [conv3s_pkg::PROD_W-1:0]      prod [conv3s_pkg::KERNEL_SIZE];
  logic signed [conv3s_pkg::COEF_W-1:0]      coef_s [conv3s_pkg::KERNEL_SIZE];
  logic signed [conv3s_pkg::PIX_W:0]         pix_s [conv3s_pkg::KERNEL_SIZE];

  always_comb begin
    for (int n = 0; n < conv3s_pkg::KERNEL_SIZE; n++) begin
      coef_s[n] = coeff[n*conv3s_pkg::COEF_W +: conv3s_pkg::COEF_W];
      pix_s[n]  = {1'b0, in_data.taps[0][n]};
      prod[n]   = coef_s[n] * pix_s[n];
    end
    data_next           = in_data;
    data_next.sum       = in_data.sum + conv3s_pkg::sext_prod(prod[0])
                          + conv3s_pkg::sext_prod(prod[1]) + conv3s_pkg::sext_prod(prod[2]);
    // move the remaining rows up for the next cell
    data_next.taps[0]   = in_data.taps[1];
    data_next.taps[1]   = in_data.taps[2];
    data_next.taps[2]   = '0;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  a_last_row_cleared: assert property (@(posedge clk) disable iff (rst)
    valid |-> data.taps[2] == '0)
    else $error("last tap row not cleared after a cell");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("cell lost or changed a stalled transaction");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid)
    else $error("cell dropped an accepted transaction");

endmodule

// ----- src/conv3x3_clamped_stream.sv -----
// ----------------------------------------------------------------------------
// conv3x3_clamped_stream
// streaming 3x3 convolution over raster pixels, result clamped to 0..255
// ----------------------------------------------------------------------------
// pipeline: a result is held in each cell register in turn, the last being the output
// throughput: one pixel per cycle while out_ready does not stall, set by the one read
//   and one write per cycle on each line store, which every pixel uses exactly once
// reset: counters, window and coefficients clear, width and height go to 512;
//   line stores are not cleared and need no clearing pass
module conv3x3_clamped_stream (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [conv3s_pkg::IDX_W-1:0]  cfg_index,
  input  logic [conv3s_pkg::CFG_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [conv3s_pkg::PIX_W-1:0]  pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [conv3s_pkg::PIX_W-1:0]  pixel_out,
  output logic                          row_end,
  output logic                          frame_end
);

  localparam int K = conv3s_pkg::KERNEL_SIZE;

  // configuration registers
  logic [conv3s_pkg::CFG_W-1:0]  coeff_rows [K];
  logic [conv3s_pkg::SIZE_W-1:0] image_width;
  logic [conv3s_pkg::SIZE_W-1:0] image_height;

  // raster position and window
  logic [conv3s_pkg::ADDR_W-1:0] column_count;
  logic [conv3s_pkg::ADDR_W-1:0] column_count_next;
  logic [conv3s_pkg::ROW_W-1:0]  row_count;
  logic [conv3s_pkg::ROW_W-1:0]  row_count_next;
  logic [conv3s_pkg::PIX_W-1:0]  window_regs [6];

  // line stores and the same-address bypass
  logic [conv3s_pkg::ADDR_W-1:0] rd_addr;
  logic [conv3s_pkg::PIX_W-1:0]  q_one;
  logic [conv3s_pkg::PIX_W-1:0]  q_two;
  logic                          fwd;
  logic [conv3s_pkg::PIX_W-1:0]  fwd_one;
  logic [conv3s_pkg::PIX_W-1:0]  fwd_two;
  logic [conv3s_pkg::PIX_W-1:0]  above1;
  logic [conv3s_pkg::PIX_W-1:0]  above2;

  logic                          accept;
  logic [conv3s_pkg::CMPW_W-1:0] width_eff;
  logic [conv3s_pkg::CMPH_W-1:0] height_eff;
  logic                          last_col;
  logic                          last_row;
  logic                          col_ok1;
  logic                          col_ok2;
  logic                          row_ok1;
  logic                          row_ok2;

  // cell chain
  conv3s_pkg::cell_data_t        stage_d [K+1];
  logic                          stage_v [K+1];
  logic                          stage_r [K+1];
  logic signed [conv3s_pkg::SUM_W-1:0] final_sum;

  // --------------------------------------------------------------------------
  // configuration writes, unknown indexes ignored
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < K; m++) begin
        coeff_rows[m] <= '0;
      end
      image_width  <= conv3s_pkg::SIZE_W'(conv3s_pkg::MAX_WIDTH);
      image_height <= conv3s_pkg::SIZE_W'(conv3s_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        conv3s_pkg::REG_COEFF_ROW0:   coeff_rows[0] <= cfg_data;
        conv3s_pkg::REG_COEFF_ROW1:   coeff_rows[1] <= cfg_data;
        conv3s_pkg::REG_COEFF_ROW2:   coeff_rows[2] <= cfg_data;
        conv3s_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[conv3s_pkg::SIZE_W-1:0];
        conv3s_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[conv3s_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // effective geometry: zero acts as one, oversize saturates
  // --------------------------------------------------------------------------
  always_comb begin
    if (image_width == '0) begin
      width_eff = conv3s_pkg::CMPW_W'(1);
    end else if (conv3s_pkg::CMPW_W'(image_width) > conv3s_pkg::CMPW_W'(conv3s_pkg::MAX_WIDTH)) begin
      width_eff = conv3s_pkg::CMPW_W'(conv3s_pkg::MAX_WIDTH);
    end else begin
      width_eff = conv3s_pkg::CMPW_W'(image_width);
    end
    if (image_height == '0) begin
      height_eff = conv3s_pkg::CMPH_W'(1);
    end else if (conv3s_pkg::CMPH_W'(image_height) > conv3s_pkg::CMPH_W'(conv3s_pkg::MAX_HEIGHT)) begin
      height_eff = conv3s_pkg::CMPH_W'(conv3s_pkg::MAX_HEIGHT);
    end else begin
      height_eff = conv3s_pkg::CMPH_W'(image_height);
    end
  end

  assign accept   = in_valid && in_ready;
  // a count at or past the size also ends the row or frame
  assign last_col = (conv3s_pkg::CMPW_W'(column_count) + conv3s_pkg::CMPW_W'(1)) >= width_eff;
  assign last_row = (conv3s_pkg::CMPH_W'(row_count) + conv3s_pkg::CMPH_W'(1)) >= height_eff;

  always_comb begin
    column_count_next = last_col ? '0 : column_count + conv3s_pkg::ADDR_W'(1);
    if (!last_col) begin
      row_count_next = row_count;
    end else if (last_row) begin
      row_count_next = '0;
    end else begin
      row_count_next = row_count + conv3s_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else if (accept) begin
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      // shift the two previous columns of each row
      window_regs[5] <= window_regs[4];
      window_regs[4] <= above2;
      window_regs[3] <= window_regs[2];
      window_regs[2] <= above1;
      window_regs[1] <= window_regs[0];
      window_regs[0] <= pixel_in;
    end
  end

  // --------------------------------------------------------------------------
  // line stores: read ahead for the next pixel's column, write this column
  // --------------------------------------------------------------------------
  assign rd_addr = accept ? column_count_next : column_count;

  conv3s_ram #(
    .WIDTH (conv3s_pkg::PIX_W),
    .DEPTH (conv3s_pkg::MAX_WIDTH)
  ) u_line_one (
    .clk   (clk),
    .we    (accept),
    .waddr (column_count),
    .wdata (pixel_in),
    .raddr (rd_addr),
    .rdata (q_one)
  );

  conv3s_ram #(
    .WIDTH (conv3s_pkg::PIX_W),
    .DEPTH (conv3s_pkg::MAX_WIDTH)
  ) u_line_two (
    .clk   (clk),
    .we    (accept),
    .waddr (column_count),
    .wdata (above1),
    .raddr (rd_addr),
    .rdata (q_two)
  );

  // one-pixel-wide rows read the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= accept && (column_count_next == column_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_one <= pixel_in;
      fwd_two <= above1;
    end
  end

  assign above1 = fwd ? fwd_one : q_one;
  assign above2 = fwd ? fwd_two : q_two;

  // --------------------------------------------------------------------------
  // tap window, taps above or left of the image read as zero
  // --------------------------------------------------------------------------
  assign col_ok1 = column_count != '0;
  assign col_ok2 = column_count >= conv3s_pkg::ADDR_W'(2);
  assign row_ok1 = row_count != '0;
  assign row_ok2 = row_count >= conv3s_pkg::ROW_W'(2);

  always_comb begin
    stage_d[0].sum       = '0;
    stage_d[0].row_end   = last_col;
    stage_d[0].frame_end = last_col && last_row;
    stage_d[0].taps[0][0] = pixel_in;
    stage_d[0].taps[0][1] = col_ok1 ? window_regs[0] : '0;
    stage_d[0].taps[0][2] = col_ok2 ? window_regs[1] : '0;
    stage_d[0].taps[1][0] = row_ok1 ? above1 : '0;
    stage_d[0].taps[1][1] = (row_ok1 && col_ok1) ? window_regs[2] : '0;
    stage_d[0].taps[1][2] = (row_ok1 && col_ok2) ? window_regs[3] : '0;
    stage_d[0].taps[2][0] = row_ok2 ? above2 : '0;
    stage_d[0].taps[2][1] = (row_ok2 && col_ok1) ? window_regs[4] : '0;
    stage_d[0].taps[2][2] = (row_ok2 && col_ok2) ? window_regs[5] : '0;
  end

  assign stage_v[0] = in_valid;
  assign in_ready   = stage_r[0];

  // --------------------------------------------------------------------------
  // one cell per kernel row, each adds its row to the running sum
  // --------------------------------------------------------------------------
  for (genvar m = 0; m < K; m++) begin : g_cell
    conv3s_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .coeff     (coeff_rows[m]),
      .in_valid  (stage_v[m]),
      .in_ready  (stage_r[m]),
      .in_data   (stage_d[m]),
      .out_valid (stage_v[m+1]),
      .out_ready (stage_r[m+1]),
      .out_data  (stage_d[m+1])
    );
  end

  // --------------------------------------------------------------------------
  // last cell is the output register; clamp on the way out
  // --------------------------------------------------------------------------
  assign stage_r[K] = out_ready;
  assign out_valid  = stage_v[K];
  assign final_sum  = stage_d[K].sum;
  assign row_end    = stage_d[K].row_end;
  assign frame_end  = stage_d[K].frame_end;

  always_comb begin
    if (final_sum < 0) begin
      pixel_out = '0;
    end else if (final_sum > $signed({1'b0, conv3s_pkg::SUM_W'(conv3s_pkg::PIXEL_MAX)})) begin
      pixel_out = conv3s_pkg::PIXEL_MAX;
    end else begin
      pixel_out = final_sum[conv3s_pkg::PIX_W-1:0];
    end
  end

  a_frame_implies_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !frame_end || row_end)
    else $error("frame end without row end");

  a_fwd_only_col0: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(column_count) == '0 && column_count == '0)
    else $error("line store bypass outside a one-pixel row");

  a_col_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !last_col |=> column_count == $past(column_count) + conv3s_pkg::ADDR_W'(1))
    else $error("column counter did not advance");

endmodule
